// File: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types, constants and helpers of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAT_LO   = 3'd0,
    CFG_PAT_HI   = 3'd1,
    CFG_WILD     = 3'd2,
    CFG_PAT_LEN  = 3'd3,
    CFG_BASE     = 3'd4,
    CFG_DELTA    = 3'd5,
    CFG_LIMIT    = 3'd6
  } cfg_index_t;

  localparam logic [4:0]  PAT_LEN_RST = 5'd1;
  localparam logic [31:0] BASE_RST    = 32'h0000_0400;
  localparam logic [31:0] DELTA_RST   = 32'h0000_0C00;
  localparam logic [7:0]  LIMIT_RST   = 8'd200;

  // one window byte as it moves down the row of cells
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } link_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // work of one accepted byte, waiting for the output stage
  typedef struct packed {
    logic        hit;
    logic        last;
    logic [7:0]  hit_number;
    logic        stopped;
    logic [31:0] offset;
  } rec_t;

  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] idx);
    logic [127:0] pat;
    pat = {hi, lo};
    return pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/wbps_in_if.sv
// ----------------------------------------------------------------------------
// wbps_in_if
// byte stream channel: one region byte per word
// ----------------------------------------------------------------------------
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: rtl/wbps_out_if.sv
// ----------------------------------------------------------------------------
// wbps_out_if
// record channel: hit records and closing total records
// ----------------------------------------------------------------------------
interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        is_total;
  logic [7:0]  hit_number;
  logic [31:0] file_offset;
  logic [31:0] rva;
  logic        stopped_early;

  modport source (output valid, output is_total, output hit_number, output file_offset,
                  output rva, output stopped_early, input ready);
  modport sink   (input valid, input is_total, input hit_number, input file_offset,
                  input rva, input stopped_early, output ready);
endinterface

// File: rtl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// one window slot: holds a byte, compares the incoming byte against its
// pattern byte and extends the match chain
// ----------------------------------------------------------------------------
module wbps_cell #(
  parameter int SLOT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  wbps_pkg::link_t     link_in,
  output wbps_pkg::link_t     link_out,
  input  logic                ok_in,
  output logic                ok_out,
  input  logic [4:0]          used_len,
  input  logic [63:0]         pat_lo,
  input  logic [63:0]         pat_hi,
  input  logic [15:0]         wild_mask
);

  logic [7:0] data;
  logic       valid;
  logic       in_use;
  logic [4:0] pidx;
  logic [7:0] pbyte;
  logic       slot_ok;

  // slot j lines up with pattern byte len-1-j
  assign in_use = 5'(SLOT) < used_len;
  assign pidx   = used_len - 5'd1 - 5'(SLOT);
  assign pbyte  = wbps_pkg::pat_byte(pat_lo, pat_hi, pidx[3:0]);
  assign slot_ok = !in_use ||
                   (link_in.valid && (wild_mask[pidx[3:0]] || link_in.data == pbyte));
  assign ok_out = ok_in && slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= link_in.valid && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= link_in.data;
    end
  end

  assign link_out.data  = data;
  assign link_out.valid = valid;

endmodule

// File: rtl/wbps_out.sv
// ----------------------------------------------------------------------------
// wbps_out
// output stage: forms the rva and sends the hit record, then the total record
// ----------------------------------------------------------------------------
module wbps_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  input  wbps_pkg::rec_t    rec,
  output logic              rec_free,
  input  logic [31:0]       rva_delta,
  wbps_out_if.source        rec_out
);

  logic        hit_v;
  logic        tot_v;
  logic [7:0]  hit_number;
  logic        stopped;
  logic [31:0] offset;
  logic [31:0] rva;
  logic        fire;
  logic        take;

  assign fire     = rec_out.valid && rec_out.ready;
  // free when empty, or when the only record left goes out now
  assign rec_free = !(hit_v || tot_v) || (fire && !(hit_v && tot_v));
  assign take     = rec_valid && rec_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_v <= 1'b0;
      tot_v <= 1'b0;
    end else if (take) begin
      hit_v <= rec.hit;
      tot_v <= rec.last;
    end else if (fire) begin
      if (hit_v) begin
        hit_v <= 1'b0;
      end else begin
        tot_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_number <= rec.hit_number;
      stopped    <= rec.stopped;
      offset     <= rec.offset;
      rva        <= rec.offset + rva_delta;
    end
  end

  assign rec_out.valid         = hit_v || tot_v;
  assign rec_out.is_total      = !hit_v;
  assign rec_out.hit_number    = hit_number;
  assign rec_out.file_offset   = hit_v ? offset : 32'd0;
  assign rec_out.rva           = hit_v ? rva : 32'd0;
  assign rec_out.stopped_early = stopped;

endmodule

// File: rtl/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// streams region bytes through a row of window cells and reports each
// masked pattern match until the hit limit stops matching, with its file offset and rva
// ----------------------------------------------------------------------------
//  channel   dir  word                                         handshake
//  byte_in   in   data_byte, last                              valid/ready
//  rec_out   out  is_total, hit_number, file_offset, rva,      valid/ready
//                 stopped_early
//  cfg       in   cfg_we, cfg_index, cfg_data                  write only
//
//  one byte per cycle while ready is high; compare, hit count and offset sum
//  happen in the accept cycle, then the record passes the record stage and
//  the output stage; a last byte with a hit sends a hit record and then a
//  total record, which throttles input; ready drops only when the output
//  stage and the record stage behind it are both full
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  wbps_in_if.sink                            byte_in,
  wbps_out_if.source                         rec_out,
  input  logic                               cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [15:0] wild_mask;
  logic [4:0]  pattern_length;
  logic [31:0] region_base;
  logic [31:0] rva_delta;
  logic [7:0]  hit_limit;

  logic [31:0] position;
  logic [7:0]  hit_count;
  logic        limit_reached;

  logic        a_valid;
  wbps_pkg::rec_t a_rec;
  wbps_pkg::rec_t a_rec_next;
  logic        b_free;
  logic        in_fire;
  logic [4:0]  used_len;
  logic        match;
  logic        hit;
  logic [7:0]  hit_count_next;
  logic        limit_next;

  wbps_pkg::cell_ctrl_t ctrl;
  wbps_pkg::link_t      links [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] ok_chain;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo         <= '0;
      pat_hi         <= '0;
      wild_mask      <= '0;
      pattern_length <= wbps_pkg::PAT_LEN_RST;
      region_base    <= wbps_pkg::BASE_RST;
      rva_delta      <= wbps_pkg::DELTA_RST;
      hit_limit      <= wbps_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::CFG_PAT_LO:  pat_lo         <= cfg_data;
        wbps_pkg::CFG_PAT_HI:  pat_hi         <= cfg_data;
        wbps_pkg::CFG_WILD:    wild_mask      <= cfg_data[15:0];
        wbps_pkg::CFG_PAT_LEN: pattern_length <= cfg_data[4:0];
        wbps_pkg::CFG_BASE:    region_base    <= cfg_data[31:0];
        wbps_pkg::CFG_DELTA:   rva_delta      <= cfg_data[31:0];
        wbps_pkg::CFG_LIMIT:   hit_limit      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the cell count as the cell count
  always_comb begin
    if (pattern_length == 5'd0) begin
      used_len = 5'd1;
    end else if (pattern_length > 5'(PATTERN_MAX)) begin
      used_len = 5'(PATTERN_MAX);
    end else begin
      used_len = pattern_length;
    end
  end

  assign byte_in.ready = !a_valid || b_free;
  assign in_fire       = byte_in.valid && byte_in.ready;
  assign ctrl.shift    = in_fire;
  assign ctrl.clear    = byte_in.last;

  assign links[0].data  = byte_in.data_byte;
  assign links[0].valid = 1'b1;
  assign ok_chain[0]    = 1'b1;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    wbps_cell #(.SLOT(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .link_in   (links[j]),
      .link_out  (links[j+1]),
      .ok_in     (ok_chain[j]),
      .ok_out    (ok_chain[j+1]),
      .used_len  (used_len),
      .pat_lo    (pat_lo),
      .pat_hi    (pat_hi),
      .wild_mask (wild_mask)
    );
  end

  assign match          = ok_chain[PATTERN_MAX];
  assign hit            = match && !limit_reached;
  assign hit_count_next = hit ? hit_count + 8'd1 : hit_count;
  assign limit_next     = limit_reached || (hit && hit_count_next >= hit_limit);

  always_comb begin
    a_rec_next.hit        = hit;
    a_rec_next.last       = byte_in.last;
    a_rec_next.hit_number = hit_count_next;
    a_rec_next.stopped    = limit_next;
    a_rec_next.offset     = region_base + position - (32'(used_len) - 32'd1);
  end

  // region state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      hit_count     <= '0;
      limit_reached <= 1'b0;
    end else if (in_fire) begin
      if (byte_in.last) begin
        position      <= '0;
        hit_count     <= '0;
        limit_reached <= 1'b0;
      end else begin
        position      <= position + 32'd1;
        hit_count     <= hit_count_next;
        limit_reached <= limit_next;
      end
    end
  end

  // record stage between the cells and the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (b_free) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_rec <= a_rec_next;
    end
  end

  wbps_out u_out (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (a_valid),
    .rec       (a_rec),
    .rec_free  (b_free),
    .rva_delta (rva_delta),
    .rec_out   (rec_out)
  );

endmodule

// File: dv/wildcard_byte_pattern_scan_tb.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_tb
// Streams byte regions into the scanner under several register settings and
// idle patterns. A behavioral scan of each accepted byte predicts the hit and
// total records, and every record that leaves the block is checked against it.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WIN_MAX        = wbps_pkg::PATTERN_MAX_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          END_CYCLES     = 20;
  localparam int          ITEMS_PER_SET  = 125;
  localparam logic [wbps_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic        is_total;
    logic [7:0]  hit_number;
    logic [31:0] file_offset;
    logic [31:0] rva;
    logic        stopped_early;
  } scan_rec_t;

  logic clk;
  logic rst;
  logic                             cfg_we;
  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data;

  wbps_in_if  byte_ch ();
  wbps_out_if rec_ch ();

  wildcard_byte_pattern_scan i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .rec_out   (rec_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [127:0] pat_bits;
  logic [15:0]  wild_bits;
  logic [4:0]   len_reg;
  logic [31:0]  base_reg;
  logic [31:0]  delta_reg;
  logic [7:0]   limit_reg;

  // scan state copies
  logic [7:0]   win_q [WIN_MAX];
  logic [31:0]  pos_cnt;
  logic [7:0]   hit_cnt;
  logic         stopped;
  int unsigned  fill_cnt;

  scan_rec_t    expected_recs [$];
  int unsigned  err_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_len();
    if (len_reg == 5'd0) return 1;
    if (len_reg > WIN_MAX) return WIN_MAX;
    return int'(len_reg);
  endfunction

  function automatic void clear_region();
    foreach (win_q[i]) win_q[i] = 8'h00;
    pos_cnt  = 32'd0;
    hit_cnt  = 8'd0;
    stopped  = 1'b0;
    fill_cnt = 0;
  endfunction

  // scan one accepted byte and queue the records it produces
  function automatic void scan_byte(input logic [7:0] b, input logic l);
    int unsigned m;
    logic        ok;
    scan_rec_t   r;
    m = eff_len();
    for (int i = WIN_MAX - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = b;
    if (fill_cnt < WIN_MAX) fill_cnt++;
    if (!stopped && fill_cnt >= m) begin
      ok = 1'b1;
      // oldest window byte lines up with pattern byte 0
      for (int k = 0; k < m; k++) begin
        if (!wild_bits[k] && win_q[m-1-k] != pat_bits[8*k +: 8]) ok = 1'b0;
      end
      if (ok) begin
        hit_cnt = hit_cnt + 8'd1;
        if (hit_cnt >= limit_reg) stopped = 1'b1;
        r.is_total      = 1'b0;
        r.hit_number    = hit_cnt;
        r.file_offset   = base_reg + pos_cnt - (m - 1);
        r.rva           = r.file_offset + delta_reg;
        r.stopped_early = stopped;
        expected_recs.insert(expected_recs.size(), r);
      end
    end
    pos_cnt = pos_cnt + 32'd1;
    if (l) begin
      r.is_total      = 1'b1;
      r.hit_number    = hit_cnt;
      r.file_offset   = 32'd0;
      r.rva           = 32'd0;
      r.stopped_early = stopped;
      expected_recs.insert(expected_recs.size(), r);
      clear_region();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last      <= l;
    do @(posedge clk); while (!byte_ch.ready);
    scan_byte(b, l);
  endtask

  // drop valid, wait for every record, then let the pipeline run dry
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high so back to back writes keep one assignment per step
  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    unique case (idx)
      wbps_pkg::CFG_PAT_LO:  pat_bits[63:0]   = val;
      wbps_pkg::CFG_PAT_HI:  pat_bits[127:64] = val;
      wbps_pkg::CFG_WILD:    wild_bits        = val[15:0];
      wbps_pkg::CFG_PAT_LEN: len_reg          = val[4:0];
      wbps_pkg::CFG_BASE:    base_reg         = val[31:0];
      wbps_pkg::CFG_DELTA:   delta_reg        = val[31:0];
      wbps_pkg::CFG_LIMIT:   limit_reg        = val[7:0];
      default: ;
    endcase
  endtask

  // upper data bits beyond each narrow register are random junk
  task automatic write_all(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [15:0] wild, input logic [4:0] len,
                           input logic [31:0] base, input logic [31:0] delta,
                           input logic [7:0] limit);
    write_reg(wbps_pkg::CFG_PAT_LO, lo);
    write_reg(wbps_pkg::CFG_PAT_HI, hi);
    write_reg(wbps_pkg::CFG_WILD, {$urandom, 16'($urandom), wild});
    write_reg(wbps_pkg::CFG_PAT_LEN, {$urandom, 27'($urandom), len});
    write_reg(wbps_pkg::CFG_BASE, {$urandom, base});
    write_reg(wbps_pkg::CFG_DELTA, {$urandom, delta});
    write_reg(wbps_pkg::CFG_LIMIT, {$urandom, 24'($urandom), limit});
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // record sink: check each word, then pick ready for the next edge
  initial begin : rec_sink
    scan_rec_t want;
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rec_ch.valid && rec_ch.ready) begin
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record, expected none actual %b %h %h %h %b", $time,
                   rec_ch.is_total, rec_ch.hit_number, rec_ch.file_offset, rec_ch.rva,
                   rec_ch.stopped_early);
          err_count++;
        end else begin
          want = expected_recs.pop_front();
          check_field("is_total", 32'(want.is_total), 32'(rec_ch.is_total));
          check_field("hit_number", 32'(want.hit_number), 32'(rec_ch.hit_number));
          check_field("file_offset", want.file_offset, rec_ch.file_offset);
          check_field("rva", want.rva, rec_ch.rva);
          check_field("stopped_early", 32'(want.stopped_early),
                      32'(rec_ch.stopped_early));
        end
      end
      rec_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("wildcard_byte_pattern_scan test failed");
    $finish;
  end

  // reset registers: single byte pattern 0x00, hit and total on the last byte
  task automatic test_defaults();
    settle();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // no compare before the window holds the pattern, offsets wrap past 2^32
  task automatic test_fill_and_wrap();
    settle();
    write_all('1, '1, 16'hffff, 5'd4, 32'hffff_fffe, 32'hffff_ffff, 8'd255);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b1);
  endtask

  // length zero acts as one, hit limit zero stops at the first hit
  task automatic test_length_zero_limit_zero();
    settle();
    write_all(64'h0000_0000_0000_00a5, 64'd0, 16'h0000, 5'd0, 32'h0000_1000, 32'd0, 8'd0);
    // unmapped index must leave everything alone
    write_reg(CFG_SPARE, '1);
    cfg_we <= 1'b0;
    send_byte(8'ha5, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h3c, 1'b1);
  endtask

  // matching stops at the limit and resumes in the next region
  task automatic test_hit_limit();
    settle();
    write_all(64'd0, 64'd0, 16'h0000, 5'd1, 32'h0000_0010, 32'h0000_0100, 8'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_scan();
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    int unsigned sent, target, m, fk, r;
    logic [7:0]  region [$];
    logic [7:0]  bv;
    logic [4:0]  len;
    logic [7:0]  limit;
    idle_tab  = '{0, 63, 0, 22};
    stall_tab = '{0, 0, 63, 22};
    for (int mode = 0; mode < 4; mode++) begin
      for (int s = 0; s < 3; s++) begin
        settle();
        send_idle_pct  = idle_tab[mode];
        recv_stall_pct = stall_tab[mode];
        if (mode * 3 + s == 0) begin
          write_all('1, '1, 16'hffff, 5'd16, 32'hffff_ffff, 32'hffff_ffff, 8'd255);
        end else if (mode * 3 + s == 1) begin
          write_all('0, '0, 16'h0000, 5'd1, 32'd0, 32'd0, 8'd1);
        end else begin
          r = $urandom_range(9);
          if (r == 0) len = 5'd0;
          else if (r == 1) len = 5'($urandom_range(17, 31));
          else if (r == 2) len = 5'd16;
          else len = 5'($urandom_range(1, 6));
          r = $urandom_range(9);
          if (r == 0) limit = 8'd0;
          else if (r == 1) limit = 8'd255;
          else limit = 8'($urandom_range(1, 12));
          write_all({$urandom, $urandom}, {$urandom, $urandom},
                    ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom & $urandom),
                    len, $urandom, $urandom, limit);
        end
        if (mode == 3 && s == 2) write_reg(CFG_SPARE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        sent = 0;
        m = eff_len();
        while (sent < ITEMS_PER_SET) begin
          region.delete();
          target = $urandom_range(1, 40);
          while (region.size() < target) begin
            r = $urandom_range(9);
            if (r < 3) begin
              // full pattern with random wild bytes, one in three broken
              fk = $urandom_range(m - 1);
              for (int k = 0; k < m; k++) begin
                bv = wild_bits[k] ? 8'($urandom) : pat_bits[8*k +: 8];
                if (r == 0 && k == fk) bv = bv ^ (8'h01 << $urandom_range(7));
                region.insert(region.size(), bv);
              end
            end else if (r < 6) begin
              region.insert(region.size(), pat_bits[8*$urandom_range(m - 1) +: 8]);
            end else begin
              region.insert(region.size(), 8'($urandom));
            end
          end
          foreach (region[i]) send_byte(region[i], i == region.size() - 1);
          sent += region.size();
        end
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last      <= 1'b0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pat_bits  = '0;
    wild_bits = '0;
    len_reg   = wbps_pkg::PAT_LEN_RST;
    base_reg  = wbps_pkg::BASE_RST;
    delta_reg = wbps_pkg::DELTA_RST;
    limit_reg = wbps_pkg::LIMIT_RST;
    clear_region();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_fill_and_wrap();
    test_length_zero_limit_zero();
    test_hit_limit();
    test_random_scan();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("wildcard_byte_pattern_scan test passed");
    end else begin
      $display("wildcard_byte_pattern_scan test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wbps_pkg.sv
rtl/wbps_in_if.sv
rtl/wbps_out_if.sv
rtl/wbps_cell.sv
rtl/wbps_out.sv
rtl/wildcard_byte_pattern_scan.sv
dv/wildcard_byte_pattern_scan_tb.sv
